// File: src/iqmd_pkg.sv
package iqmd_pkg;

  // CORDIC start value: about K * 2^30 in Q2.30
  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
  localparam int unsigned CORDIC_N = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_SCALE,
    ST_MAC,
    ST_ACC,
    ST_SQR,
    ST_ROOT,
    ST_RND,
    ST_DIV,
    ST_OUT
  } iqmd_state_t;

  // arctan(2^-i) in units of 2^32 per turn
  function automatic logic signed [32:0] atan_angle(input logic [3:0] idx);
    logic signed [32:0] a;
    unique case (idx)
      4'd0:  a = 33'sd536870912;
      4'd1:  a = 33'sd316933406;
      4'd2:  a = 33'sd167458907;
      4'd3:  a = 33'sd85004756;
      4'd4:  a = 33'sd42667331;
      4'd5:  a = 33'sd21354465;
      4'd6:  a = 33'sd10679838;
      4'd7:  a = 33'sd5340245;
      4'd8:  a = 33'sd2670163;
      4'd9:  a = 33'sd1335087;
      4'd10: a = 33'sd667544;
      4'd11: a = 33'sd333772;
      4'd12: a = 33'sd166886;
      4'd13: a = 33'sd83443;
      4'd14: a = 33'sd41722;
      4'd15: a = 33'sd20861;
    endcase
    return a;
  endfunction

endpackage

// File: src/iq_mix_decimate_am_envelope.sv
// AM envelope demodulator: each transaction brings two raw unsigned I/Q byte pairs, which are
// summed into one signed complex sample, rotated by a phase accumulator that advances by
// cfg_wdata (phase step, 32768 = pi) and added to I/Q integrators. Every DECIM transactions one
// result gives the integrated magnitude over DECIM*256 as unsigned Q1.15, saturated at 65535.
// The block takes one transaction at a time and holds in_stall high while it works. A
// transaction that does not close a decimation window passes through an accept step, 16
// iterations of the shared CORDIC stage, a step that rounds sine and cosine, the products
// on the single 32x32 multiplier and an accumulate step. The transaction that closes a
// window goes on through two squares on the same multiplier, a 32-step bit-serial square
// root, a rounding step, a multiply by the reciprocal of DECIM on that multiplier and the
// load of the output register; that load waits for as long as an earlier result is
// still stalled in the output register. Write cfg_wdata only while idle.
module iq_mix_decimate_am_envelope #(
  parameter int DECIM      = 25,
  parameter int PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_i_first,
  input  logic [7:0]  in_q_first,
  input  logic [7:0]  in_i_second,
  input  logic [7:0]  in_q_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_magnitude
);
  import iqmd_pkg::*;

  localparam int STEP_UP  = (PHASE_BITS >= 16) ? (PHASE_BITS - 16) : 0;
  localparam int STEP_DN  = (PHASE_BITS < 16) ? (16 - PHASE_BITS) : 0;
  localparam int CNT_W    = $clog2(DECIM + 1);
  localparam int D_HALF   = DECIM * 128;
  localparam int T_W      = 25;
  // reciprocal of DECIM, exact for every dividend below 2^T_W
  localparam int RCP_L    = $clog2(DECIM);
  localparam int RCP_SH   = T_W + RCP_L;
  localparam longint RCP_M = ((64'sd1 <<< RCP_SH) + longint'(DECIM) - 64'sd1) / longint'(DECIM);

  iqmd_state_t state_r, state_nxt;
  logic [4:0]  ctr_r, ctr_nxt;

  logic signed [15:0]      phase_step_r;
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic signed [31:0]      sum_i_r, sum_q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    out_valid_r;
  logic [15:0]             out_mag_r;

  logic signed [9:0]  si_r, sq_r;
  logic signed [32:0] x_r, y_r, z_r;
  logic               flip_r;
  logic signed [15:0] c_r, s_r;
  logic signed [63:0] prod_r;
  logic signed [25:0] ir_r, qr_r;
  logic [63:0]        v_r, res_r, bit_r;
  logic [T_W-1:0]     t_r;
  logic [15:0]        q_r;
  logic               sat_r;

  logic signed [39:0] step_ext, inc_wide;
  logic [31:0]        angle;
  logic signed [32:0] z_in;
  logic signed [9:0]  si_in, sq_in;
  logic signed [32:0] dx, dy, at;
  logic signed [33:0] xf, yf, cw, sw;
  logic signed [31:0] mul_a, mul_b;
  logic signed [32:0] acc_i, acc_q;
  logic [63:0]        rb;
  logic [32:0]        rnd_sum;
  logic [T_W-1:0]     t_val;
  logic [63:0]        q_full;
  logic               dump;
  logic               out_free;
  logic               load_out;

  // phase increment scaled to PHASE_BITS
  assign step_ext  = 40'(phase_step_r);
  assign inc_wide  = (step_ext <<< STEP_UP) >>> STEP_DN;
  assign phase_nxt = phase_r + inc_wide[PHASE_BITS-1:0];
  assign angle     = 32'(phase_nxt) << (32 - PHASE_BITS);
  assign z_in      = 33'($signed(angle));

  assign si_in = $signed({2'b00, in_i_first}) + $signed({2'b00, in_i_second}) - 10'sd256;
  assign sq_in = $signed({2'b00, in_q_first}) + $signed({2'b00, in_q_second}) - 10'sd256;

  assign dx = y_r >>> ctr_r[3:0];
  assign dy = x_r >>> ctr_r[3:0];
  assign at = atan_angle(ctr_r[3:0]);

  assign xf = flip_r ? -34'(x_r) : 34'(x_r);
  assign yf = flip_r ? -34'(y_r) : 34'(y_r);
  assign cw = (xf + 34'sd16384) >>> 15;
  assign sw = (yf + 34'sd16384) >>> 15;

  assign acc_i = 33'(sum_i_r) + 33'(ir_r);
  assign acc_q = 33'(sum_q_r) + 33'(qr_r);

  assign rb      = res_r + bit_r;
  assign rnd_sum = {1'b0, res_r[31:0]} + 33'(D_HALF);
  assign t_val   = rnd_sum[32:8];
  assign q_full  = $unsigned(prod_r) >> RCP_SH;

  assign dump     = (cnt_r == CNT_W'(DECIM - 1));
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MAC: begin
        unique case (ctr_r[1:0])
          2'd0: begin mul_a = 32'(c_r); mul_b = 32'(si_r); end
          2'd1: begin mul_a = 32'(s_r); mul_b = 32'(sq_r); end
          2'd2: begin mul_a = 32'(s_r); mul_b = 32'(si_r); end
          2'd3: begin mul_a = 32'(c_r); mul_b = 32'(sq_r); end
        endcase
      end
      ST_SQR: begin
        mul_a = ctr_r[0] ? sum_q_r : sum_i_r;
        mul_b = ctr_r[0] ? sum_q_r : sum_i_r;
      end
      ST_DIV: begin
        mul_a = 32'(RCP_M);
        mul_b = $signed(32'(t_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_ROT;
      ST_ROT:   if (ctr_r == 5'(CORDIC_N - 1)) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_MAC;
      ST_MAC:   if (ctr_r == 5'd4) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = dump ? ST_SQR : ST_IDLE;
      ST_SQR:   if (ctr_r == 5'd2) state_nxt = ST_ROOT;
      ST_ROOT:  if (ctr_r == 5'd31) state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_DIV;
      ST_DIV:   if (ctr_r == 5'd1) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    ctr_nxt = (state_nxt != state_r) ? 5'd0 : ctr_r + 5'd1;
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    load_out = (state_r == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ctr_r        <= '0;
      phase_step_r <= '0;
      phase_r      <= '0;
      sum_i_r      <= '0;
      sum_q_r      <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      if (cfg_we) begin
        phase_step_r <= $signed(cfg_wdata);
      end
      if (state_r == ST_IDLE && in_valid) begin
        phase_r <= phase_nxt;
      end
      if (state_r == ST_ACC) begin
        // saturate each integrator at the signed 32-bit bounds
        if (acc_i[32] != acc_i[31]) begin
          sum_i_r <= acc_i[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          sum_i_r <= acc_i[31:0];
        end
        if (acc_q[32] != acc_q[31]) begin
          sum_q_r <= acc_q[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          sum_q_r <= acc_q[31:0];
        end
        cnt_r <= dump ? '0 : cnt_r + CNT_W'(1);
      end
      if (state_r == ST_SQR && ctr_r == 5'd2) begin
        sum_i_r <= '0;
        sum_q_r <= '0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        si_r <= si_in;
        sq_r <= sq_in;
        x_r  <= CORDIC_K;
        y_r  <= '0;
        // fold angles beyond +-pi/2 by pi, negate at the end
        if (z_in > 33'sd1073741824) begin
          z_r    <= z_in - 33'sd2147483648;
          flip_r <= 1'b1;
        end else if (z_in < -33'sd1073741824) begin
          z_r    <= z_in + 33'sd2147483648;
          flip_r <= 1'b1;
        end else begin
          z_r    <= z_in;
          flip_r <= 1'b0;
        end
      end
      ST_ROT: begin
        if (!z_r[32]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
      end
      ST_SCALE: begin
        priority if (cw > 34'sd32767) c_r <= 16'sh7fff;
        else if (cw < -34'sd32768) c_r <= 16'sh8000;
        else c_r <= cw[15:0];
        priority if (sw > 34'sd32767) s_r <= 16'sh7fff;
        else if (sw < -34'sd32768) s_r <= 16'sh8000;
        else s_r <= sw[15:0];
      end
      ST_MAC: begin
        unique case (ctr_r[2:0])
          3'd1:    ir_r <= prod_r[25:0];
          3'd2:    ir_r <= ir_r + prod_r[25:0];
          3'd3:    qr_r <= -prod_r[25:0];
          3'd4:    qr_r <= qr_r + prod_r[25:0];
          default: ir_r <= ir_r;
        endcase
      end
      ST_SQR: begin
        if (ctr_r == 5'd1) begin
          v_r <= prod_r;
        end else if (ctr_r == 5'd2) begin
          v_r   <= v_r + 64'(prod_r);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      ST_ROOT: begin
        if (v_r >= rb) begin
          v_r   <= v_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_RND: begin
        t_r <= t_val;
      end
      ST_DIV: begin
        // product of the rounded root and the reciprocal is read from the multiplier register
        if (ctr_r == 5'd1) begin
          sat_r <= |q_full[63:16];
          q_r   <= q_full[15:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_mag_r <= sat_r ? 16'hffff : q_r;
        end
      end
      default: begin
        q_r <= q_r;
      end
    endcase
  end

endmodule
